/* src/pprfc_pkg.sv */
// ----------------------------------------------------------------------------
// Ping-pong repeat frame counter package
// Shared widths, action and command codes, register indexes and the
// command type that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pprfc_pkg;

    localparam int POS_W      = 16;
    localparam int HITS_W     = 16;
    localparam int PROG_W     = POS_W + 1;
    localparam int ACTION_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_CNT_W = $clog2(POS_W);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENDLESS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_UP = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_START      = 3'd1,
        ACT_RESET      = 3'd2,
        ACT_SET_ACTIVE = 3'd3,
        ACT_ADD        = 3'd4,
        ACT_SUB        = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_START,
        OP_RESET,
        OP_SET_ACTIVE,
        OP_ADD,
        OP_SUB
    } t_op;

    typedef struct packed {
        t_op  op;
        logic want;
    } t_cmd;

endpackage

/* src/pprfc_in_if.sv */
// ----------------------------------------------------------------------------
// Action channel
// Valid/ready channel that carries one action beat into the counter.
// ----------------------------------------------------------------------------
interface pprfc_in_if;

    logic                         valid;
    logic                         ready;
    logic [pprfc_pkg::ACTION_W-1:0] action;
    logic                         active_value;

    modport source (output valid, output action, output active_value, input ready);
    modport sink   (input valid, input action, input active_value, output ready);

endinterface

/* src/pprfc_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one counter status beat out.
// ----------------------------------------------------------------------------
interface pprfc_out_if;

    logic                          valid;
    logic                          ready;
    logic [pprfc_pkg::POS_W-1:0]   position;
    logic [pprfc_pkg::HITS_W-1:0]  repetitions;
    logic                          counting_up;
    logic                          running;
    logic [pprfc_pkg::PROG_W-1:0]  progress;

    modport source (
        output valid, output position, output repetitions, output counting_up,
        output running, output progress, input ready
    );
    modport sink (
        input valid, input position, input repetitions, input counting_up,
        input running, input progress, output ready
    );

endinterface

/* src/ping_pong_repeat_frame_counter_top.sv */
// ----------------------------------------------------------------------------
// Ping-pong repeat frame counter, top level
// Every action beat yields one status beat. The front end takes a beat per
// cycle while the two-entry command queue is not full; the back end applies
// each command to the counter, runs the bit-serial divide that forms the
// position/period fraction, and then loads the output register once the
// previous status beat has been taken. It takes no new command until the
// last one is through. A status beat waiting on the output does not stop the
// front end from taking new actions until the queue fills.
// ----------------------------------------------------------------------------
module ping_pong_repeat_frame_counter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pprfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pprfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pprfc_in_if.sink                           i_in,
    pprfc_out_if.source                        o_out
);

    logic            push;
    pprfc_pkg::t_cmd push_cmd;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    pprfc_pkg::t_cmd q_cmd;

    pprfc_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    pprfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pprfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

endmodule

/* src/pprfc_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts action beats and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module pprfc_front (
    pprfc_in_if.sink        i_in,
    input  logic            i_full,
    output logic            o_push,
    output pprfc_pkg::t_cmd o_cmd
);

    pprfc_pkg::t_op op;

    always_comb begin
        unique case (pprfc_pkg::t_action'(i_in.action))
            pprfc_pkg::ACT_TICK:       op = pprfc_pkg::OP_TICK;
            pprfc_pkg::ACT_START:      op = pprfc_pkg::OP_START;
            pprfc_pkg::ACT_RESET:      op = pprfc_pkg::OP_RESET;
            pprfc_pkg::ACT_SET_ACTIVE: op = pprfc_pkg::OP_SET_ACTIVE;
            pprfc_pkg::ACT_ADD:        op = pprfc_pkg::OP_ADD;
            pprfc_pkg::ACT_SUB:        op = pprfc_pkg::OP_SUB;
            default:                   op = pprfc_pkg::OP_NONE;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_cmd.op   = op;
    assign o_cmd.want = i_in.active_value;

endmodule

/* src/pprfc_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pprfc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pprfc_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pprfc_pkg::t_cmd o_cmd
);

    pprfc_pkg::t_cmd                 r_mem [pprfc_pkg::QUEUE_DEPTH];
    logic [pprfc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pprfc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pprfc_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == pprfc_pkg::QCNT_W'(pprfc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/pprfc_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Holds the configuration and counter state, applies one command, runs the
// bit-serial progress divide and loads the result register.
// ----------------------------------------------------------------------------
module pprfc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pprfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pprfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_q_valid,
    input  pprfc_pkg::t_cmd                    i_q_cmd,
    output logic                               o_q_pop,
    pprfc_out_if.source                        o_out
);

    localparam int PW = pprfc_pkg::POS_W;
    localparam int HW = pprfc_pkg::HITS_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state                              r_state;
    logic [PW-1:0]                       r_period;
    logic [HW-1:0]                       r_limit;
    logic                                r_loop;
    logic                                r_endless;
    logic [PW-1:0]                       r_pos;
    logic                                r_dir;
    logic [HW-1:0]                       r_hits;
    logic                                r_active;
    logic [PW-1:0]                       r_rem;
    logic [PW-1:0]                       r_quo;
    logic [pprfc_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                                r_ovalid;
    logic [PW-1:0]                       r_opos;
    logic [HW-1:0]                       r_ohits;
    logic                                r_odir;
    logic                                r_oactive;
    logic [pprfc_pkg::PROG_W-1:0]        r_oprog;

    logic [PW-1:0] n_pos;
    logic          n_dir;
    logic [HW-1:0] n_hits;
    logic          n_active;
    logic [PW-1:0] start_pos;
    logic [PW-1:0] step_pos;
    logic          hit;
    logic [HW-1:0] hits_inc;

    logic [PW:0]                  rem_sh;
    logic                         rem_ge;
    logic [PW:0]                  rem_sub;
    logic [pprfc_pkg::PROG_W-1:0] prog;

    assign start_pos = r_dir ? '0 : r_period;

    always_comb begin
        n_pos    = r_pos;
        n_dir    = r_dir;
        n_hits   = r_hits;
        n_active = r_active;
        step_pos = r_pos;
        hit      = 1'b0;
        hits_inc = (r_hits != '1) ? r_hits + 1'b1 : r_hits;
        case (i_q_cmd.op)
            pprfc_pkg::OP_TICK: begin
                if (r_active) begin
                    if (r_dir) begin
                        step_pos = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
                        hit      = (step_pos >= r_period);
                    end else begin
                        step_pos = (r_pos != '0) ? r_pos - 1'b1 : r_pos;
                        hit      = (step_pos == '0);
                    end
                    n_pos = step_pos;
                    if (hit) begin
                        n_hits = hits_inc;
                        if (r_endless || (hits_inc < r_limit)) begin
                            if (r_loop) begin
                                n_dir = !r_dir;
                            end else begin
                                n_pos = start_pos;
                            end
                        end
                    end
                    if (!r_endless && (n_hits >= r_limit)) begin
                        n_active = 1'b0;
                    end
                end
            end
            pprfc_pkg::OP_START: begin
                n_pos    = start_pos;
                n_hits   = '0;
                n_active = 1'b1;
            end
            pprfc_pkg::OP_RESET: begin
                n_pos  = start_pos;
                n_hits = '0;
            end
            pprfc_pkg::OP_SET_ACTIVE: begin
                if (!r_active && i_q_cmd.want) begin
                    n_pos  = start_pos;
                    n_hits = '0;
                end
                n_active = i_q_cmd.want;
            end
            pprfc_pkg::OP_ADD: begin
                if (r_pos < r_period) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            pprfc_pkg::OP_SUB: begin
                if (r_pos != '0) begin
                    n_pos = r_pos - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign rem_sh  = {r_rem, 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, r_period});
    assign rem_sub = rem_sh - {1'b0, r_period};

    always_comb begin
        if (r_period == '0) begin
            prog = '0;
        end else if (r_pos >= r_period) begin
            prog = {1'b1, {PW{1'b0}}};
        end else begin
            prog = {1'b0, r_quo};
        end
    end

    assign o_q_pop           = (r_state == S_IDLE) && i_q_valid;
    assign o_out.valid       = r_ovalid;
    assign o_out.position    = r_opos;
    assign o_out.repetitions = r_ohits;
    assign o_out.counting_up = r_odir;
    assign o_out.running     = r_oactive;
    assign o_out.progress    = r_oprog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= '0;
            r_limit   <= '0;
            r_loop    <= 1'b0;
            r_endless <= 1'b0;
            r_pos     <= '0;
            r_dir     <= 1'b1;
            r_hits    <= '0;
            r_active  <= 1'b0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_pos    <= n_pos;
                        r_dir    <= n_dir;
                        r_hits   <= n_hits;
                        r_active <= n_active;
                        r_rem    <= n_pos;
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
                    r_quo <= {r_quo[PW-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == pprfc_pkg::DIV_CNT_W'(PW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_opos    <= r_pos;
                        r_ohits   <= r_hits;
                        r_odir    <= r_dir;
                        r_oactive <= r_active;
                        r_oprog   <= prog;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pprfc_pkg::REG_PERIOD:  r_period  <= i_cfg_data[PW-1:0];
                    pprfc_pkg::REG_LIMIT:   r_limit   <= i_cfg_data[HW-1:0];
                    pprfc_pkg::REG_LOOP:    r_loop    <= i_cfg_data[0];
                    pprfc_pkg::REG_ENDLESS: r_endless <= i_cfg_data[0];
                    pprfc_pkg::REG_START_UP: begin
                        r_dir    <= i_cfg_data[0];
                        r_pos    <= i_cfg_data[0] ? '0 : r_period;
                        r_active <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* src/pprfc_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the result port of the counter top level over time.
// ----------------------------------------------------------------------------
module pprfc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [pprfc_pkg::POS_W-1:0]       i_out_position,
    input logic [pprfc_pkg::PROG_W-1:0]      i_out_progress
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_position)
            && $stable(i_out_progress))
        else $error("Stalled result beat changed.");

    a_full_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_progress[pprfc_pkg::PROG_W-1] |->
            (i_out_progress[pprfc_pkg::POS_W-1:0] == '0) && (i_out_position != '0))
        else $error("Full progress with a zero position or a nonzero fraction.");

endmodule

bind ping_pong_repeat_frame_counter_top pprfc_checker u_pprfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position),
    .i_out_progress (o_out.progress)
);
